### src/rts_pkg.sv
// Shared types and codes for the RTOS task scheduler.
package rts_pkg;

  localparam int MAX_TASKS_DEF = 16;

  localparam logic [2:0] FN_TICK   = 3'd0;
  localparam logic [2:0] FN_YIELD  = 3'd1;
  localparam logic [2:0] FN_WAIT   = 3'd2;
  localparam logic [2:0] FN_SET    = 3'd3;
  localparam logic [2:0] FN_CREATE = 3'd4;

  localparam logic [1:0] ST_READY     = 2'd0;
  localparam logic [1:0] ST_ACTIVE    = 2'd1;
  localparam logic [1:0] ST_WAIT      = 2'd2;
  localparam logic [1:0] ST_SUSPENDED = 2'd3;

  typedef struct packed {
    logic latch;
    logic exec;
    logic wake_step;
    logic yprep;
    logic pick_step;
    logic commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       delay_nz;
    logic       scan_last;
    logic       pick_done;
    logic       out_free;
  } sts_t;

endpackage

### src/rtos_task_scheduler.sv
// Top level of the RTOS task scheduler.
// One operation per input transaction, one result per operation. Set status,
// create and unused codes go from execution straight to the result; a yield,
// or a wait with a nonzero delay, adds a pick pass over the task table, in
// priority or round robin mode; a tick adds a wake pass before its pick pass.
// Both passes walk the task table one slot per cycle. Results sit in an output
// register, so the next operation starts while a result waits. The mode
// register may be written any time the block is idle.
module rtos_task_scheduler #(
  parameter int MAX_TASKS = rts_pkg::MAX_TASKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [3:0]  in_task_sel,
  input  logic [1:0]  in_new_status,
  input  logic [31:0] in_delay_ticks,
  input  logic [7:0]  in_task_priority,
  input  logic [31:0] in_task_period,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_next_task,
  output logic        out_switch_needed,
  output logic [3:0]  out_created_id,
  output logic        out_op_error,
  output logic [31:0] out_tick_now,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_scheduler_mode
);

  rts_pkg::cmd_t cmd;
  rts_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  rts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rts_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_func            (in_func),
    .in_task_sel        (in_task_sel),
    .in_new_status      (in_new_status),
    .in_delay_ticks     (in_delay_ticks),
    .in_task_priority   (in_task_priority),
    .in_task_period     (in_task_period),
    .cfg_valid          (cfg_valid),
    .cfg_scheduler_mode (cfg_scheduler_mode),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_next_task      (out_next_task),
    .out_switch_needed  (out_switch_needed),
    .out_created_id     (out_created_id),
    .out_op_error       (out_op_error),
    .out_tick_now       (out_tick_now)
  );

endmodule

### src/rts_ctrl.sv
// Sequencer for the scheduler: steps an operation through its phases.
module rts_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rts_pkg::sts_t sts,
  output rts_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_WAKE   = 3'd2;
  localparam logic [2:0] S_YPREP  = 3'd3;
  localparam logic [2:0] S_PICK   = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (sts.func)
          rts_pkg::FN_TICK:  state_nxt = S_WAKE;
          rts_pkg::FN_YIELD: state_nxt = S_YPREP;
          rts_pkg::FN_WAIT:  state_nxt = sts.delay_nz ? S_YPREP : S_FIN;
          default:           state_nxt = S_FIN;
        endcase
      end
      S_WAKE: begin
        cmd.wake_step = 1'b1;
        if (sts.scan_last) state_nxt = S_YPREP;
      end
      S_YPREP: begin
        cmd.yprep = 1'b1;
        state_nxt = S_PICK;
      end
      S_PICK: begin
        cmd.pick_step = 1'b1;
        if (sts.pick_done) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> state_r == S_EXEC)
    else $error("accepted transaction did not start execution");
  a_load_fin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> state_r == S_IDLE)
    else $error("result load did not return to idle");
  a_pick_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> $past(cmd.pick_step))
    else $error("commit without a finished pick");
`endif

endmodule

### src/rts_dp.sv
// Scheduler datapath: task tables, tick counter, table scan and result register.
module rts_dp #(
  parameter int MAX_TASKS = rts_pkg::MAX_TASKS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  rts_pkg::cmd_t cmd,
  output rts_pkg::sts_t sts,
  input  logic [2:0]    in_func,
  input  logic [3:0]    in_task_sel,
  input  logic [1:0]    in_new_status,
  input  logic [31:0]   in_delay_ticks,
  input  logic [7:0]    in_task_priority,
  input  logic [31:0]   in_task_period,
  input  logic          cfg_valid,
  input  logic          cfg_scheduler_mode,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [3:0]    out_next_task,
  output logic          out_switch_needed,
  output logic [3:0]    out_created_id,
  output logic          out_op_error,
  output logic [31:0]   out_tick_now
);

  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);

  logic [1:0]    status_r [MAX_TASKS];
  logic [31:0]   wake_r   [MAX_TASKS];
  logic [7:0]    prio_r   [MAX_TASKS];
  logic [31:0]   period_r [MAX_TASKS];
  logic [31:0]   act_r    [MAX_TASKS];

  logic          mode_r;
  logic [2:0]    func_r;
  logic [3:0]    sel_r;
  logic [1:0]    nst_r;
  logic [31:0]   delay_r;
  logic [7:0]    nprio_r;
  logic [31:0]   nperiod_r;
  logic [IW-1:0] before_r;
  logic [IW-1:0] created_r;
  logic          err_r;
  logic [31:0]   tick_r;
  logic [CW-1:0] tc_r;
  logic [IW-1:0] active_r;
  logic [CW-1:0] ptr_r;
  logic [CW-1:0] steps_r;
  logic [IW-1:0] best_r;
  logic [7:0]    best_prio_r;

  logic          out_valid_r;
  logic [3:0]    out_next_r;
  logic          out_sw_r;
  logic [3:0]    out_cid_r;
  logic          out_err_r;
  logic [31:0]   out_tick_r;

  logic [CW-1:0] cur_inc, cur_nxt, steps_nxt;
  logic [CW:0]   ptr_inc;
  logic [IW-1:0] rd_idx;
  logic          rr_zero, rr_found, prio_cand, in_range;

  always_comb begin
    cur_inc   = ptr_r + CW'(1);
    cur_nxt   = (cur_inc >= tc_r) ? CW'(1) : cur_inc;
    steps_nxt = steps_r + CW'(1);
    ptr_inc   = {1'b0, ptr_r} + (CW+1)'(1);
    rd_idx    = (cmd.pick_step && !mode_r) ? cur_nxt[IW-1:0] : ptr_r[IW-1:0];
    in_range  = ptr_r < tc_r;
    rr_zero   = steps_nxt == tc_r;
    rr_found  = status_r[rd_idx] == rts_pkg::ST_READY;
    prio_cand = in_range && (status_r[rd_idx] == rts_pkg::ST_READY) &&
                (prio_r[rd_idx] > best_prio_r) &&
                (((active_r == rd_idx) && ((tick_r - act_r[rd_idx]) < period_r[rd_idx])) ||
                 (best_r == '0));
  end

  assign sts.func      = func_r;
  assign sts.delay_nz  = delay_r != 32'd0;
  assign sts.scan_last = ptr_inc >= {1'b0, tc_r};
  assign sts.pick_done = mode_r ? (ptr_inc >= {1'b0, tc_r}) : (rr_zero || rr_found);
  assign sts.out_free  = !out_valid_r || out_ready;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      tick_r   <= '0;
      tc_r     <= CW'(1);
      active_r <= '0;
      for (int i = 0; i < MAX_TASKS; i++) status_r[i] <= rts_pkg::ST_READY;
    end else begin
      if (cfg_valid) mode_r <= cfg_scheduler_mode;
      if (cmd.exec) begin
        case (func_r)
          rts_pkg::FN_TICK: tick_r <= tick_r + 32'd1;
          rts_pkg::FN_WAIT: begin
            if (delay_r != 32'd0) status_r[active_r] <= rts_pkg::ST_WAIT;
          end
          rts_pkg::FN_SET: begin
            if (32'(sel_r) < MAX_TASKS) status_r[IW'(sel_r)] <= nst_r;
          end
          rts_pkg::FN_CREATE: begin
            if (tc_r < CW'(MAX_TASKS - 1)) begin
              status_r[tc_r[IW-1:0]] <= rts_pkg::ST_READY;
              tc_r <= tc_r + CW'(1);
            end
          end
          default: ;
        endcase
      end
      if (cmd.wake_step && in_range && status_r[rd_idx] == rts_pkg::ST_WAIT &&
          wake_r[rd_idx] == tick_r) begin
        status_r[rd_idx] <= rts_pkg::ST_READY;
      end
      if (cmd.yprep && status_r[active_r] == rts_pkg::ST_ACTIVE) begin
        status_r[active_r] <= rts_pkg::ST_READY;
      end
      if (cmd.commit) begin
        status_r[best_r] <= rts_pkg::ST_ACTIVE;
        active_r         <= best_r;
      end
    end
  end

  // Task data and scan registers.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r    <= in_func;
      sel_r     <= in_task_sel;
      nst_r     <= in_new_status;
      delay_r   <= in_delay_ticks;
      nprio_r   <= in_task_priority;
      nperiod_r <= in_task_period;
      before_r  <= active_r;
      created_r <= '0;
      err_r     <= 1'b0;
    end
    if (cmd.exec) begin
      ptr_r <= CW'(1);
      case (func_r)
        rts_pkg::FN_WAIT: begin
          if (delay_r != 32'd0) wake_r[active_r] <= tick_r + delay_r;
        end
        rts_pkg::FN_CREATE: begin
          if (tc_r < CW'(MAX_TASKS - 1)) begin
            wake_r[tc_r[IW-1:0]]   <= 32'd0;
            prio_r[tc_r[IW-1:0]]   <= nprio_r;
            period_r[tc_r[IW-1:0]] <= nperiod_r;
            created_r              <= tc_r[IW-1:0];
          end else begin
            err_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (cmd.wake_step) begin
      if (in_range && status_r[rd_idx] == rts_pkg::ST_WAIT && wake_r[rd_idx] == tick_r) begin
        wake_r[rd_idx] <= 32'd0;
      end
      ptr_r <= ptr_inc[CW-1:0];
    end
    if (cmd.yprep) begin
      ptr_r       <= mode_r ? CW'(1) : CW'(active_r);
      steps_r     <= '0;
      best_r      <= '0;
      best_prio_r <= 8'd0;
    end
    if (cmd.pick_step) begin
      if (mode_r) begin
        if (prio_cand) begin
          best_r      <= rd_idx;
          best_prio_r <= prio_r[rd_idx];
        end
        ptr_r <= ptr_inc[CW-1:0];
      end else begin
        ptr_r   <= cur_nxt;
        steps_r <= steps_nxt;
        best_r  <= rr_zero ? '0 : cur_nxt[IW-1:0];
      end
    end
    if (!rst_n) begin
      for (int i = 0; i < MAX_TASKS; i++) act_r[i] <= '0;
    end else if (cmd.commit && mode_r && best_r != active_r) begin
      act_r[best_r] <= tick_r;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_next_r <= 4'(active_r);
      out_sw_r   <= active_r != before_r;
      out_cid_r  <= 4'(created_r);
      out_err_r  <= err_r;
      out_tick_r <= tick_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_next_task     = out_next_r;
  assign out_switch_needed = out_sw_r;
  assign out_created_id    = out_cid_r;
  assign out_op_error      = out_err_r;
  assign out_tick_now      = out_tick_r;

`ifndef ASSERT_OFF
  a_active_range: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(active_r) < tc_r)
    else $error("active task beyond task count");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    tc_r < CW'(MAX_TASKS) && tc_r != '0)
    else $error("task count out of range");
  a_best_prio: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pick_step && mode_r && best_r != '0) |-> best_prio_r != 8'd0)
    else $error("priority pick holds a slot without priority");
`endif

endmodule

### sim/rtos_task_scheduler_checker.sv
// Checker for the task scheduler: tracks the task table and compares every result.
module rtos_task_scheduler_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [3:0]  in_task_sel,
  input  logic [1:0]  in_new_status,
  input  logic [31:0] in_delay_ticks,
  input  logic [7:0]  in_task_priority,
  input  logic [31:0] in_task_period,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  out_next_task,
  input  logic        out_switch_needed,
  input  logic [3:0]  out_created_id,
  input  logic        out_op_error,
  input  logic [31:0] out_tick_now,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_scheduler_mode,
  output int          fail_count,
  output int          pending,
  output int          ops_seen,
  output int          decisions_seen,
  output int          switches_seen,
  output int          full_errors_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = rts_pkg::MAX_TASKS_DEF;

  typedef struct packed {
    logic [3:0]  next_task;
    logic        switch_needed;
    logic [3:0]  created_id;
    logic        op_error;
    logic [31:0] tick_now;
  } decision_t;

  logic        prio_mode;
  logic [1:0]  status_tbl [NSLOT];
  logic [31:0] wake_tbl   [NSLOT];
  logic [7:0]  prio_tbl   [NSLOT];
  logic [31:0] period_tbl [NSLOT];
  logic [31:0] act_tbl    [NSLOT];
  int          task_cnt;
  int          running;
  logic [31:0] ticks;
  decision_t   decisions_q[$];

  function automatic int pick_round_robin();
    int cur;
    int steps;
    cur = running;
    steps = 0;
    do begin
      steps++;
      cur++;
      if (cur >= task_cnt) cur = 1;
    end while (steps < task_cnt && cur < NSLOT && status_tbl[cur] != rts_pkg::ST_READY);
    if (steps == task_cnt || cur >= NSLOT) cur = 0;
    return cur;
  endfunction

  function automatic int pick_priority();
    int best;
    best = 0;
    for (int i = 1; i < task_cnt && i < NSLOT; i++) begin
      if (status_tbl[i] != rts_pkg::ST_READY) continue;
      if (prio_tbl[i] <= prio_tbl[best]) continue;
      if (running == i && (ticks - act_tbl[i]) < period_tbl[i]) best = i;
      else if (best == 0) best = i;
    end
    if (best != running) act_tbl[best] = ticks;
    return best;
  endfunction

  function automatic void reschedule();
    if (status_tbl[running] == rts_pkg::ST_ACTIVE) status_tbl[running] = rts_pkg::ST_READY;
    running = prio_mode ? pick_priority() : pick_round_robin();
    status_tbl[running] = rts_pkg::ST_ACTIVE;
  endfunction

  function automatic decision_t apply_sched_op(logic [2:0] fn, logic [3:0] sel,
                                               logic [1:0] nst, logic [31:0] dly,
                                               logic [7:0] prio, logic [31:0] per);
    decision_t d;
    int prev;
    d = '0;
    prev = running;
    case (fn)
      rts_pkg::FN_TICK: begin
        ticks++;
        for (int i = 1; i < task_cnt && i < NSLOT; i++) begin
          if (status_tbl[i] == rts_pkg::ST_WAIT && wake_tbl[i] == ticks) begin
            status_tbl[i] = rts_pkg::ST_READY;
            wake_tbl[i] = '0;
          end
        end
        reschedule();
      end
      rts_pkg::FN_YIELD: reschedule();
      rts_pkg::FN_WAIT: begin
        if (dly != 0) begin
          status_tbl[running] = rts_pkg::ST_WAIT;
          wake_tbl[running] = ticks + dly;
          reschedule();
        end
      end
      rts_pkg::FN_SET: status_tbl[sel] = nst;
      rts_pkg::FN_CREATE: begin
        if (task_cnt >= NSLOT - 1) begin
          d.op_error = 1'b1;
        end else begin
          status_tbl[task_cnt] = rts_pkg::ST_READY;
          wake_tbl[task_cnt] = '0;
          prio_tbl[task_cnt] = prio;
          period_tbl[task_cnt] = per;
          d.created_id = 4'(task_cnt);
          task_cnt++;
        end
      end
      default: ;
    endcase
    d.next_task = 4'(running);
    d.switch_needed = (running != prev);
    d.tick_now = ticks;
    return d;
  endfunction

  assign pending = decisions_q.size();

  always @(posedge clk) begin
    decision_t exp_d;
    if (!rst_n) begin
      prio_mode <= 1'b0;
      for (int i = 0; i < NSLOT; i++) begin
        status_tbl[i] = rts_pkg::ST_READY;
        wake_tbl[i] = '0;
        prio_tbl[i] = '0;
        period_tbl[i] = '0;
        act_tbl[i] = '0;
      end
      task_cnt = 1;
      running = 0;
      ticks = '0;
      decisions_q.delete();
      fail_count <= 0;
      ops_seen <= 0;
      decisions_seen <= 0;
      switches_seen <= 0;
      full_errors_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) prio_mode <= cfg_scheduler_mode;
      if (in_valid && in_ready) begin
        decisions_q.push_back(apply_sched_op(in_func, in_task_sel, in_new_status,
                                             in_delay_ticks, in_task_priority,
                                             in_task_period));
        ops_seen <= ops_seen + 1;
      end
      if (out_valid && out_ready) begin
        decisions_seen <= decisions_seen + 1;
        switches_seen <= switches_seen + out_switch_needed;
        full_errors_seen <= full_errors_seen + out_op_error;
        if (decisions_q.size() == 0) begin
          $display("%0t: result with nothing outstanding: next=%0d tick=%0d", $time,
                   out_next_task, out_tick_now);
          fail_count <= fail_count + 1;
        end else begin
          exp_d = decisions_q.pop_front();
          if (exp_d != {out_next_task, out_switch_needed, out_created_id, out_op_error,
                        out_tick_now}) begin
            $display("%0t: mismatch expected next=%0d sw=%0b id=%0d err=%0b tick=%0d",
                     $time, exp_d.next_task, exp_d.switch_needed, exp_d.created_id,
                     exp_d.op_error, exp_d.tick_now);
            $display("%0t:          actual   next=%0d sw=%0b id=%0d err=%0b tick=%0d",
                     $time, out_next_task, out_switch_needed, out_created_id,
                     out_op_error, out_tick_now);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

### sim/tb_rtos_task_scheduler.sv
// Testbench top for the task scheduler: stimulus, idling and the verdict.
module tb_rtos_task_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 48;
  localparam logic [2:0] FN_UNUSED_LO  = 3'd5;
  localparam logic [2:0] FN_UNUSED_MID = 3'd6;
  localparam logic [2:0] FN_UNUSED_HI  = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_func = '0;
  logic [3:0]  in_task_sel = '0;
  logic [1:0]  in_new_status = '0;
  logic [31:0] in_delay_ticks = '0;
  logic [7:0]  in_task_priority = '0;
  logic [31:0] in_task_period = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_next_task;
  logic        out_switch_needed;
  logic [3:0]  out_created_id;
  logic        out_op_error;
  logic [31:0] out_tick_now;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_scheduler_mode = 1'b0;

  int  fail_count, pending, ops_seen, decisions_seen, switches_seen, full_errors_seen;
  int  cycles = 0;
  bit  sender_idles = 1'b1;
  bit  receiver_stalls = 1'b1;
  int  ready_hold = 0;

  always #6 clk = ~clk;

  rtos_task_scheduler u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_func, .in_task_sel, .in_new_status,
    .in_delay_ticks, .in_task_priority, .in_task_period, .out_valid, .out_ready,
    .out_next_task, .out_switch_needed, .out_created_id, .out_op_error, .out_tick_now,
    .cfg_valid, .cfg_ready, .cfg_scheduler_mode
  );

  rtos_task_scheduler_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_func, .in_task_sel, .in_new_status,
    .in_delay_ticks, .in_task_priority, .in_task_period, .out_valid, .out_ready,
    .out_next_task, .out_switch_needed, .out_created_id, .out_op_error, .out_tick_now,
    .cfg_valid, .cfg_ready, .cfg_scheduler_mode, .fail_count, .pending, .ops_seen,
    .decisions_seen, .switches_seen, .full_errors_seen
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: alternate ready and stall episodes, or stay ready when stalls are off.
  always @(negedge clk) begin
    if (!receiver_stalls) begin
      out_ready = 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      out_ready = ~out_ready;
      ready_hold = out_ready ? $urandom_range(0, 12) : idle_len();
    end
  end

  task automatic send_op(logic [2:0] fn, logic [3:0] sel, logic [1:0] nst,
                         logic [31:0] dly, logic [7:0] prio, logic [31:0] per);
    int gap;
    gap = sender_idles ? idle_len() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_func = fn;
    in_task_sel = sel;
    in_new_status = nst;
    in_delay_ticks = dly;
    in_task_priority = prio;
    in_task_period = per;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_filler(logic [2:0] fn, logic [3:0] sel, logic [1:0] nst,
                             logic [31:0] dly);
    send_op(fn, sel, nst, dly, 8'($urandom), $urandom);
  endtask

  task automatic write_mode(logic mode);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_scheduler_mode = mode;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_scheduler_mode = 1'($urandom);
  endtask

  task automatic send_random_op();
    int r;
    logic [31:0] dly;
    logic [31:0] per;
    r = $urandom_range(0, 99);
    dly = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6);
    per = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 8);
    if (r < 35)      send_filler(rts_pkg::FN_TICK, 4'($urandom), 2'($urandom), $urandom);
    else if (r < 50) send_filler(rts_pkg::FN_YIELD, 4'($urandom), 2'($urandom), $urandom);
    else if (r < 65) send_filler(rts_pkg::FN_WAIT, 4'($urandom), 2'($urandom), dly);
    else if (r < 83) send_filler(rts_pkg::FN_SET, 4'($urandom), 2'($urandom), $urandom);
    else if (r < 95) send_op(rts_pkg::FN_CREATE, 4'($urandom), 2'($urandom), $urandom,
                             8'($urandom), per);
    else             send_filler(3'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI)),
                                 4'($urandom), 2'($urandom), $urandom);
  endtask

  task automatic run_directed();
    send_filler(rts_pkg::FN_TICK, '0, '0, '0);
    send_filler(rts_pkg::FN_YIELD, '0, '0, '0);
    send_filler(rts_pkg::FN_WAIT, '0, '0, 32'd0);
    send_op(rts_pkg::FN_CREATE, '0, '0, '0, 8'd0, 32'd0);
    send_op(rts_pkg::FN_CREATE, '1, '1, '1, 8'hFF, 32'hFFFF_FFFF);
    send_op(rts_pkg::FN_CREATE, '0, '0, '0, 8'd10, 32'd3);
    send_filler(rts_pkg::FN_YIELD, '0, '0, '0);
    send_filler(rts_pkg::FN_WAIT, '0, '0, 32'd2);
    send_filler(rts_pkg::FN_TICK, '0, '0, '0);
    send_filler(rts_pkg::FN_TICK, '0, '0, '0);
    // slot above the created range still gets written
    send_filler(rts_pkg::FN_SET, 4'd15, rts_pkg::ST_SUSPENDED, '0);
    send_filler(rts_pkg::FN_SET, 4'd1, rts_pkg::ST_WAIT, '0);
    send_filler(rts_pkg::FN_SET, 4'd1, rts_pkg::ST_ACTIVE, '0);
    send_filler(rts_pkg::FN_SET, 4'd1, rts_pkg::ST_READY, '0);
    send_filler(FN_UNUSED_LO, '1, '1, '1);
    send_filler(FN_UNUSED_MID, '0, '0, '0);
    send_filler(FN_UNUSED_HI, '1, '1, '1);
    // wake time wraps past the top of the counter
    send_filler(rts_pkg::FN_WAIT, '0, '0, 32'hFFFF_FFFF);
    // suspend every task but idle, fall back to idle, then send a wait from idle
    for (int s = 1; s < 4; s++) send_filler(rts_pkg::FN_SET, 4'(s), rts_pkg::ST_SUSPENDED, '0);
    send_filler(rts_pkg::FN_YIELD, '0, '0, '0);
    send_filler(rts_pkg::FN_WAIT, '0, '0, 32'd5);
    send_filler(rts_pkg::FN_TICK, '0, '0, '0);
    send_filler(rts_pkg::FN_SET, 4'd2, rts_pkg::ST_READY, '0);
    send_filler(rts_pkg::FN_TICK, '0, '0, '0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      write_mode(ph[0]);
      if (ph == 0) run_directed();
      for (int n = 0; n < 270; n++) begin
        // every so often choose anew, for each side, whether the sender idles and the receiver stalls
        if (n % 90 == 0) begin
          sender_idles = ($urandom_range(0, 2) != 0);
          receiver_stalls = ($urandom_range(0, 2) != 0);
        end
        send_random_op();
      end
    end
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d operations in both scheduling modes, %0d results checked",
             ops_seen, decisions_seen);
    $display("task switches seen: %0d, table-full errors seen: %0d",
             switches_seen, full_errors_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
